// ===== src/cdenc_pkg.sv =====
// Shared types, constants and GF(256) helpers for the CD Mode 1 sector encoder.
package cdenc_pkg;

    localparam int STORE_DEPTH = 2052;   // sector bytes 12..2063
    localparam int OM_DEPTH    = 288;    // sector bytes 2064..2351
    localparam int IDX_W       = 12;
    localparam int OM_AW       = 9;
    localparam int ST_AW       = 12;

    localparam logic [IDX_W-1:0] OM_SPLIT   = 12'd2052;
    localparam logic [19:0]      MAX_FAD    = 20'd881999;
    localparam logic [20:0]      FAD_OFFSET = 21'd150;
    localparam logic [19:0]      COUNT_MAX  = 20'hFFFFF;
    localparam logic [63:0]      SYNC_WORD  = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [6:0]       DIV_FRAMES = 7'd75;
    localparam logic [6:0]       DIV_SECS   = 7'd60;
    // Reciprocals rounded up: 2^27 / 75 and 2^26 / 60, exact for any 20-bit dividend.
    localparam logic [20:0]      RECIP_FRAMES = 21'd1789570;
    localparam logic [20:0]      RECIP_SECS   = 21'd1118482;

    localparam logic [6:0]       P_ROWS  = 7'd86;
    localparam logic [5:0]       P_COLS  = 6'd24;
    localparam logic [6:0]       P_STEP  = 7'd86;
    localparam logic [IDX_W:0]   P_SIZE  = 13'd2064;
    localparam logic [OM_AW-1:0] P_BASE  = 9'd12;
    localparam logic [6:0]       Q_ROWS  = 7'd52;
    localparam logic [5:0]       Q_COLS  = 6'd43;
    localparam logic [6:0]       Q_STEP  = 7'd88;
    localparam logic [IDX_W:0]   Q_SIZE  = 13'd2236;
    localparam logic [OM_AW-1:0] Q_BASE  = 9'd184;
    localparam logic [IDX_W-1:0] Q_STRIDE = 12'd86;
    localparam logic [7:0]       GF_INV3 = 8'hF4;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } par_rd_t;

    typedef struct packed {
        logic             en;
        logic [OM_AW-1:0] addr;
        logic [7:0]       data;
    } par_wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_FRAME,
        ST_DIV_MIN,
        ST_HDR,
        ST_DATA,
        ST_TAIL,
        ST_PAR_P,
        ST_PAR_Q,
        ST_OUT,
        ST_DRAIN
    } top_state_t;

    typedef enum logic [1:0] {
        PS_IDLE,
        PS_RUN,
        PS_ROWEND,
        PS_SECOND
    } par_state_t;

    function automatic logic [7:0] gf_dbl(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
    endfunction

    // Multiplication by the inverse of 3, i.e. division by 3 in the field.
    function automatic logic [7:0] gf_div3(input logic [7:0] x);
        logic [7:0] acc;
        logic [7:0] p;
        acc = 8'h00;
        p = x;
        for (int k = 0; k < 8; k++)
        begin
            if (GF_INV3[k])
                acc = acc ^ p;
            p = gf_dbl(p);
        end
        return acc;
    endfunction

    // Minutes of 100 and above are coded as 0xA0 plus the excess.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [3:0] tens;
        logic [7:0] rest;
        tens = 4'd0;
        if (v >= 8'd100)
            return v + 8'd60;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= 8'(k * 10))
                tens = 4'(k);
        end
        rest = v - 8'(tens) * 8'd10;
        return {tens, rest[3:0]};
    endfunction

endpackage

// ===== src/cd_mode1_sector_encoder_top.sv =====
// Top level of the CD Mode 1 raw sector encoder: sequencer, sector stores and output register.
//
//  channel   signals                                  beat taken when
//  -------   --------------------------------------   ---------------------------
//  input     start, busy, data_word[63:0]             start high and busy low
//  result    result_valid, out_word, last_of_sector   every cycle result_valid is high
//  config    first_lba_we, first_lba[19:0]            every cycle first_lba_we is high
//
// A data word is accepted in the idle state; its eight bytes are then written into the store and the
// EDC, one byte per cycle on the single store write port.
// For the first word of a sector, two reciprocal divisions first split the address into minute,
// second and frame, and 16 header bytes pass through the EDC.
// The last word adds 12 tail bytes, P and Q parity at one byte per cycle within each row (each row
// ends with its two check-byte writes), two hand-overs and 288 bytes read out; no stalls.
module cd_mode1_sector_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] data_word,
    input  logic        first_lba_we,
    input  logic [19:0] first_lba,
    output logic        result_valid,
    output logic [63:0] out_word,
    output logic        last_of_sector
);
    import cdenc_pkg::*;

    top_state_t  state_reg, state_next;
    logic [8:0]  cnt_reg, cnt_next;
    logic [7:0]  pos_reg, pos_next;
    logic [19:0] count_reg, count_next;
    logic [19:0] lba_reg;
    logic [63:0] data_reg, data_next;
    logic [7:0]  min_reg, min_next;
    logic [7:0]  sec_reg, sec_next;
    logic [7:0]  frm_reg, frm_next;
    logic        valid_reg, valid_next;
    logic [63:0] word_reg, word_next;
    logic        last_reg, last_next;
    logic [63:0] asm_reg, asm_next;
    logic        od_vld_reg, od_vld_next;
    logic [8:0]  od_addr_reg;
    logic        sel_d_reg;

    logic [7:0]  store_mem [STORE_DEPTH];
    logic [7:0]  om_mem [OM_DEPTH];
    logic [7:0]  st_q_reg, om_q_reg;

    logic             st_we, st_re, om_we, om_re;
    logic [ST_AW-1:0] st_waddr, st_raddr;
    logic [7:0]       st_wdata, om_wdata;
    logic [OM_AW-1:0] om_waddr, om_raddr;

    logic        div_start, div_done;
    logic [19:0] div_dividend, div_quo;
    logic        div_sel_secs;
    logic [6:0]  div_rem;

    logic        edc_en, edc_clear;
    logic [7:0]  edc_data;
    logic [31:0] edc_crc;

    logic        par_start, par_sel_q, par_done;
    logic [7:0]  par_rdata;
    par_rd_t     par_rd;
    par_wr_t     par_wr;

    logic [21:0] fad_sum;
    logic [19:0] fad;
    logic [7:0]  hdr_byte;
    logic [IDX_W-1:0] par_om_idx;

    cdenc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .sel_secs  (div_sel_secs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    cdenc_edc u_edc (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (edc_en),
        .clear (edc_clear),
        .data  (edc_data),
        .crc   (edc_crc)
    );

    cdenc_parity u_parity (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (par_start),
        .sel_q   (par_sel_q),
        .rd_data (par_rdata),
        .rd_req  (par_rd),
        .wr_req  (par_wr),
        .done    (par_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= 9'd0;
            pos_reg    <= 8'd0;
            count_reg  <= 20'd0;
            lba_reg    <= 20'd0;
            valid_reg  <= 1'b0;
            od_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
            od_vld_reg <= od_vld_next;
            if (first_lba_we)
                lba_reg <= first_lba;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        min_reg     <= min_next;
        sec_reg     <= sec_next;
        frm_reg     <= frm_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
        asm_reg     <= asm_next;
        od_addr_reg <= cnt_reg;
        sel_d_reg   <= (par_rd.idx >= OM_SPLIT);
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            store_mem[st_waddr] <= st_wdata;
        if (st_re)
            st_q_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (om_we)
            om_mem[om_waddr] <= om_wdata;
        if (om_re)
            om_q_reg <= om_mem[om_raddr];
    end

    // Bytes below the split come from the store, the rest from the tail memory.
    assign par_rdata  = sel_d_reg ? om_q_reg : st_q_reg;
    assign par_om_idx = par_rd.idx - OM_SPLIT;
    assign st_raddr   = par_rd.idx;
    assign st_re      = par_rd.en && (par_rd.idx < OM_SPLIT);

    assign fad_sum = {2'b0, lba_reg} + 22'(FAD_OFFSET) + {2'b0, count_reg};
    assign fad     = (fad_sum > {2'b0, MAX_FAD}) ? MAX_FAD : fad_sum[19:0];

    always_comb
    begin
        priority if (cnt_reg[3:0] == 4'd0 || cnt_reg[3:0] == 4'd11)
            hdr_byte = 8'h00;
        else if (cnt_reg[3:0] == 4'd12)
            hdr_byte = min_reg;
        else if (cnt_reg[3:0] == 4'd13)
            hdr_byte = sec_reg;
        else if (cnt_reg[3:0] == 4'd14)
            hdr_byte = frm_reg;
        else if (cnt_reg[3:0] == 4'd15)
            hdr_byte = 8'h01;
        else
            hdr_byte = 8'hFF;
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        data_next    = data_reg;
        min_next     = min_reg;
        sec_next     = sec_reg;
        frm_next     = frm_reg;
        valid_next   = 1'b0;
        word_next    = word_reg;
        last_next    = 1'b0;
        asm_next     = asm_reg;
        od_vld_next  = 1'b0;
        div_start    = 1'b0;
        div_dividend = fad;
        div_sel_secs = 1'b0;
        edc_en       = 1'b0;
        edc_clear    = 1'b0;
        edc_data     = hdr_byte;
        par_start    = 1'b0;
        par_sel_q    = 1'b0;
        st_we        = 1'b0;
        st_waddr     = ST_AW'(cnt_reg[3:0]) - ST_AW'(12);
        st_wdata     = hdr_byte;
        om_we        = par_wr.en;
        om_waddr     = par_wr.addr;
        om_wdata     = par_wr.data;
        om_re        = par_rd.en && (par_rd.idx >= OM_SPLIT);
        om_raddr     = par_om_idx[OM_AW-1:0];
        busy         = (state_reg != ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    data_next = data_word;
                    cnt_next  = 9'd0;
                    if (pos_reg == 8'd0)
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV_FRAME;
                    end
                    else
                        state_next = ST_DATA;
                end
            end
            ST_DIV_FRAME:
            begin
                if (div_done)
                begin
                    frm_next     = to_bcd({1'b0, div_rem});
                    div_start    = 1'b1;
                    div_dividend = div_quo;
                    div_sel_secs = 1'b1;
                    state_next   = ST_DIV_MIN;
                end
            end
            ST_DIV_MIN:
            begin
                if (div_done)
                begin
                    min_next   = to_bcd(div_quo[7:0]);
                    sec_next   = to_bcd({1'b0, div_rem});
                    cnt_next   = 9'd0;
                    state_next = ST_HDR;
                end
            end
            ST_HDR:
            begin
                edc_en    = 1'b1;
                edc_clear = (cnt_reg == 9'd0);
                st_we     = (cnt_reg >= 9'd12);
                cnt_next  = cnt_reg + 9'd1;
                if (cnt_reg == 9'd0)
                begin
                    valid_next = 1'b1;
                    word_next  = SYNC_WORD;
                end
                if (cnt_reg == 9'd15)
                begin
                    valid_next = 1'b1;
                    word_next  = {8'h01, frm_reg, sec_reg, min_reg, 8'h00, 24'hFF_FFFF};
                    cnt_next   = 9'd0;
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                edc_en   = 1'b1;
                edc_data = data_reg[{cnt_reg[2:0], 3'b000} +: 8];
                st_we    = 1'b1;
                st_waddr = ST_AW'({pos_reg, cnt_reg[2:0]}) + ST_AW'(4);
                st_wdata = edc_data;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd7)
                begin
                    valid_next = 1'b1;
                    word_next  = data_reg;
                    pos_next   = pos_reg + 8'd1;
                    cnt_next   = 9'd0;
                    state_next = (pos_reg == 8'd255) ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                // EDC bytes, then eight zero bytes, ahead of the parity area.
                om_we    = 1'b1;
                om_waddr = cnt_reg;
                om_wdata = (cnt_reg < 9'd4) ? edc_crc[{cnt_reg[1:0], 3'b000} +: 8] : 8'h00;
                cnt_next = cnt_reg + 9'd1;
                if (cnt_reg == 9'd11)
                begin
                    par_start  = 1'b1;
                    state_next = ST_PAR_P;
                end
            end
            ST_PAR_P:
            begin
                if (par_done)
                begin
                    par_start  = 1'b1;
                    par_sel_q  = 1'b1;
                    state_next = ST_PAR_Q;
                end
            end
            ST_PAR_Q:
            begin
                if (par_done)
                begin
                    cnt_next   = 9'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                om_re       = 1'b1;
                om_raddr    = cnt_reg;
                od_vld_next = 1'b1;
                cnt_next    = cnt_reg + 9'd1;
                if (cnt_reg == 9'(OM_DEPTH - 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                cnt_next = 9'd0;
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + 20'd1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Tail bytes are gathered into a word; the eighth byte sends it.
        if (od_vld_reg)
        begin
            if (od_addr_reg[2:0] == 3'd7)
            begin
                valid_next = 1'b1;
                word_next  = {om_q_reg, asm_reg[55:0]};
                last_next  = (od_addr_reg == 9'(OM_DEPTH - 1));
            end
            else
                asm_next[{od_addr_reg[2:0], 3'b000} +: 8] = om_q_reg;
        end
    end

    assign result_valid   = valid_reg;
    assign out_word       = word_reg;
    assign last_of_sector = last_reg;

endmodule

// ===== src/cdenc_div.sv =====
// Constant divider by 75 or 60 for the sector address split, using reciprocal multiplication.
module cdenc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [19:0] dividend,
    input  logic        sel_secs,
    output logic        done,
    output logic [19:0] quotient,
    output logic [6:0]  remainder
);
    import cdenc_pkg::*;

    logic        mul_reg, mul_next;
    logic        sub_reg, sub_next;
    logic        done_reg, done_next;
    logic        sel_reg, sel_next;
    logic [19:0] dvd_reg, dvd_next;
    logic [19:0] quo_reg, quo_next;
    logic [6:0]  rem_reg, rem_next;
    logic [40:0] product;
    logic [19:0] back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        product   = 41'(dvd_reg) * 41'(sel_reg ? RECIP_SECS : RECIP_FRAMES);
        back      = quo_reg * 20'(sel_reg ? DIV_SECS : DIV_FRAMES);
        mul_next  = 1'b0;
        sub_next  = 1'b0;
        done_next = 1'b0;
        sel_next  = sel_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            mul_next = 1'b1;
            sel_next = sel_secs;
            dvd_next = dividend;
        end
        else if (mul_reg)
        begin
            quo_next = sel_reg ? 20'(product[40:26]) : 20'(product[40:27]);
            sub_next = 1'b1;
        end
        else if (sub_reg)
        begin
            rem_next  = 7'(dvd_reg - back);
            done_next = 1'b1;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== src/cdenc_edc.sv =====
// Byte-wide reflected 32-bit CRC accumulator for the sector EDC field.
module cdenc_edc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        clear,
    input  logic [7:0]  data,
    output logic [31:0] crc
);
    import cdenc_pkg::*;

    logic [31:0] crc_reg, crc_next;

    function automatic logic [31:0] edc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = {1'b0, r[31:1]} ^ (r[0] ? 32'hD801_8001 : 32'h0);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= 32'd0;
        else
            crc_reg <= crc_next;
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (en)
            crc_next = edc_byte(clear ? 32'd0 : crc_reg, data);
    end

    assign crc = crc_reg;

endmodule

// ===== src/cdenc_parity.sv =====
// P and Q parity engine: walks the product code one stored byte per cycle, pausing at each row end.
module cdenc_parity (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                sel_q,
    input  logic [7:0]          rd_data,
    output cdenc_pkg::par_rd_t  rd_req,
    output cdenc_pkg::par_wr_t  wr_req,
    output logic                done
);
    import cdenc_pkg::*;

    par_state_t       state_reg, state_next;
    logic             q_reg, q_next;
    logic [6:0]       row_reg, row_next;
    logic [5:0]       col_reg, col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       a_reg, a_next;
    logic [7:0]       b_reg, b_next;
    logic             dv_reg, dv_next;
    logic             done_reg, done_next;

    logic [6:0]       rows;
    logic [5:0]       cols;
    logic [6:0]       step;
    logic [IDX_W:0]   size;
    logic [OM_AW-1:0] base;
    logic [IDX_W:0]   idx_sum;
    logic [IDX_W-1:0] idx_adv;
    logic [7:0]       a_acc, b_acc, fin;

    function automatic logic [IDX_W-1:0] row_start(input logic q, input logic [6:0] r);
        if (q)
            return IDX_W'(IDX_W'(r[6:1]) * Q_STRIDE) + IDX_W'(r[0]);
        return IDX_W'(r);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            dv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= dv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        row_reg <= row_next;
        col_reg <= col_next;
        idx_reg <= idx_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    always_comb
    begin
        rows    = q_reg ? Q_ROWS : P_ROWS;
        cols    = q_reg ? Q_COLS : P_COLS;
        step    = q_reg ? Q_STEP : P_STEP;
        size    = q_reg ? Q_SIZE : P_SIZE;
        base    = q_reg ? Q_BASE : P_BASE;
        idx_sum = {1'b0, idx_reg} + (IDX_W+1)'(step);
        idx_adv = (idx_sum >= size) ? IDX_W'(idx_sum - size) : idx_sum[IDX_W-1:0];
        a_acc   = gf_dbl(a_reg ^ rd_data);
        b_acc   = b_reg ^ rd_data;
        fin     = gf_div3(gf_dbl(a_acc) ^ b_acc);

        state_next = state_reg;
        q_next     = q_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        idx_next   = idx_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        dv_next    = 1'b0;
        done_next  = 1'b0;
        rd_req     = '0;
        wr_req     = '0;

        unique case (state_reg)
            PS_IDLE:
            begin
                if (start)
                begin
                    q_next     = sel_q;
                    row_next   = 7'd0;
                    col_next   = 6'd0;
                    idx_next   = '0;
                    a_next     = 8'd0;
                    b_next     = 8'd0;
                    state_next = PS_RUN;
                end
            end
            PS_RUN:
            begin
                rd_req.en  = 1'b1;
                rd_req.idx = idx_reg;
                dv_next    = 1'b1;
                idx_next   = idx_adv;
                col_next   = col_reg + 6'd1;
                if (dv_reg)
                begin
                    a_next = a_acc;
                    b_next = b_acc;
                end
                if (col_reg == cols - 6'd1)
                    state_next = PS_ROWEND;
            end
            PS_ROWEND:
            begin
                // The last byte of the row arrives now and the first check byte is written; the second follows.
                wr_req.en   = 1'b1;
                wr_req.addr = base + OM_AW'(row_reg);
                wr_req.data = fin;
                a_next      = fin;
                b_next      = b_acc;
                state_next  = PS_SECOND;
            end
            PS_SECOND:
            begin
                wr_req.en   = 1'b1;
                wr_req.addr = base + OM_AW'(row_reg) + OM_AW'(rows);
                wr_req.data = a_reg ^ b_reg;
                if (row_reg == rows - 7'd1)
                begin
                    done_next  = 1'b1;
                    state_next = PS_IDLE;
                end
                else
                begin
                    row_next   = row_reg + 7'd1;
                    col_next   = 6'd0;
                    idx_next   = row_start(q_reg, row_reg + 7'd1);
                    a_next     = 8'd0;
                    b_next     = 8'd0;
                    state_next = PS_RUN;
                end
            end
            default:
            begin
                state_next = PS_IDLE;
            end
        endcase
    end

    assign done = done_reg;

endmodule

// ===== verif/cd_mode1_sector_encoder_top_tb.sv =====
// Self-checking testbench for the CD Mode 1 raw sector encoder, with a built-in sector predictor.
module cd_mode1_sector_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 60000;
    localparam int WORDS_IN    = 256;
    localparam int RAW_BYTES   = 2352;

    typedef struct {
        logic [63:0] word;
        logic        last;
    } sector_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] data_word = '0;
    logic        first_lba_we = 1'b0;
    logic [19:0] first_lba = '0;
    logic        busy;
    logic        result_valid;
    logic [63:0] out_word;
    logic        last_of_sector;

    // Predictor state.
    logic [7:0]  raw_sector [RAW_BYTES];
    logic [7:0]  gf_twice [256];
    logic [7:0]  gf_untwice [256];
    logic [31:0] edc_crc;
    logic [7:0]  word_pos;
    logic [19:0] sectors_done;
    logic [19:0] lba_reg;

    sector_word_t expected_words [$];
    int          mismatches;
    int          cycles;
    int          sender_idle_pct;

    cd_mode1_sector_encoder_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .data_word      (data_word),
        .first_lba_we   (first_lba_we),
        .first_lba      (first_lba),
        .result_valid   (result_valid),
        .out_word       (out_word),
        .last_of_sector (last_of_sector)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] edc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = (c >> 1) ^ (c[0] ? 32'hD801_8001 : 32'h0);
        return c;
    endfunction

    function automatic logic [7:0] bcd_of(input int unsigned v);
        if (v < 100)
            return 8'(((v / 10) << 4) | (v % 10));
        return 8'(8'hA0 + (v - 100));
    endfunction

    function automatic logic [63:0] word_at(input int unsigned off);
        logic [63:0] w;
        for (int i = 0; i < 8; i++)
            w[8*i +: 8] = raw_sector[off + i];
        return w;
    endfunction

    task automatic reed_solomon(input int unsigned rows, input int unsigned cols,
                                input int unsigned stride, input int unsigned step,
                                input int unsigned dst);
        int unsigned total;
        int unsigned idx;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  t;
        total = rows * cols;
        for (int unsigned r = 0; r < rows; r++)
        begin
            idx = (r >> 1) * stride + (r & 1);
            a = 8'h00;
            b = 8'h00;
            for (int unsigned c = 0; c < cols; c++)
            begin
                t = raw_sector[12 + idx];
                idx += step;
                if (idx >= total)
                    idx -= total;
                a = gf_twice[a ^ t];
                b = b ^ t;
            end
            a = gf_untwice[gf_twice[a] ^ b];
            raw_sector[dst + r] = a;
            raw_sector[dst + r + rows] = a ^ b;
        end
    endtask

    task automatic push_word(input int unsigned off, input logic last);
        sector_word_t e;
        e.word = word_at(off);
        e.last = last;
        expected_words.push_back(e);
    endtask

    // Works out every sector word that one accepted data beat releases.
    task automatic predict_sector_words(input logic [63:0] w);
        logic [21:0]  sum;
        int unsigned  fad;
        int unsigned  base;
        if (word_pos == 0)
        begin
            sum = 22'(lba_reg) + 22'd150 + 22'(sectors_done);
            fad = (sum > 22'd881999) ? 881999 : int'(sum);
            raw_sector[0] = 8'h00;
            for (int i = 1; i <= 10; i++)
                raw_sector[i] = 8'hFF;
            raw_sector[11] = 8'h00;
            raw_sector[12] = bcd_of(fad / 4500);
            raw_sector[13] = bcd_of((fad / 75) % 60);
            raw_sector[14] = bcd_of(fad % 75);
            raw_sector[15] = 8'h01;
            edc_crc = '0;
            for (int i = 0; i < 16; i++)
                edc_crc = edc_step(edc_crc, raw_sector[i]);
            push_word(0, 1'b0);
            push_word(8, 1'b0);
        end
        base = 16 + int'(word_pos) * 8;
        for (int i = 0; i < 8; i++)
        begin
            raw_sector[base + i] = w[8*i +: 8];
            edc_crc = edc_step(edc_crc, w[8*i +: 8]);
        end
        push_word(base, 1'b0);
        if (word_pos == 8'd255)
        begin
            for (int i = 0; i < 4; i++)
                raw_sector[2064 + i] = edc_crc[8*i +: 8];
            for (int i = 2068; i < 2076; i++)
                raw_sector[i] = 8'h00;
            reed_solomon(86, 24, 2, 86, 2076);
            reed_solomon(52, 43, 86, 88, 2248);
            for (int k = 258; k < 294; k++)
                push_word(k * 8, k == 293);
            if (sectors_done != 20'hFFFFF)
                sectors_done++;
        end
        word_pos++;
    endtask

    // Holds start high with a new beat until it is taken; idles at random before it.
    task automatic send_beat(input logic [63:0] w);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        data_word <= w;
        do
            @(posedge clk);
        while (busy);
        predict_sector_words(w);
    endtask

    task automatic stop_sending();
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_lba(input logic [19:0] v);
        wait_drained();
        first_lba_we <= 1'b1;
        first_lba <= v;
        @(posedge clk);
        first_lba_we <= 1'b0;
        lba_reg = v;
        @(posedge clk);
    endtask

    // The register at its top value drives the address past its ceiling,
    // which also gives a minute well above 99.
    task automatic test_saturated_header();
        sender_idle_pct = 21;
        write_lba(20'hFFFFF);
        send_beat(64'h0);
    endtask

    task automatic test_data_extremes();
        send_beat('1);
        send_beat(64'h0123_4567_89AB_CDEF);
        send_beat(64'h5555_5555_5555_5555);
        send_beat(64'hAAAA_AAAA_AAAA_AAAA);
        send_beat(64'h8000_0000_0000_0001);
        for (int i = 6; i < 84; i++)
            send_beat({$urandom, $urandom});
    endtask

    // Heavy sender idling, with one pause until every result has come.
    task automatic test_idle_sender();
        sender_idle_pct = 52;
        for (int i = 84; i < 170; i++)
        begin
            if (i == 128)
                pause_until_drained();
            send_beat({$urandom, $urandom});
        end
    endtask

    // Back-to-back beats up to the end of the sector, which releases EDC and parity.
    task automatic test_back_to_back_tail();
        sender_idle_pct = 0;
        for (int i = 170; i < WORDS_IN; i++)
            send_beat({$urandom, $urandom});
        stop_sending();
    endtask

    always @(posedge clk)
    begin
        sector_word_t e;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected sector word %h last %b", out_word, last_of_sector);
            end
            else
            begin
                e = expected_words.pop_front();
                if (out_word !== e.word || last_of_sector !== e.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Sector word mismatch: expected %h last %b, got %h last %b",
                                 e.word, e.last, out_word, last_of_sector);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        sender_idle_pct = 21;
        edc_crc = '0;
        word_pos = '0;
        sectors_done = '0;
        lba_reg = '0;
        for (int i = 0; i < RAW_BYTES; i++)
            raw_sector[i] = 8'h00;
        for (int i = 0; i < 256; i++)
        begin
            gf_twice[i] = 8'((i << 1) ^ ((i & 8'h80) != 0 ? 9'h11D : 9'h000));
            gf_untwice[8'(i) ^ gf_twice[i]] = 8'(i);
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_saturated_header();
        test_data_extremes();
        test_idle_sender();
        test_back_to_back_tail();

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/cdenc_pkg.sv
src/cdenc_div.sv
src/cdenc_edc.sv
src/cdenc_parity.sv
src/cd_mode1_sector_encoder_top.sv
verif/cd_mode1_sector_encoder_top_tb.sv
